[hw/rtl/max_xor_subarray_top_macros.svh]
// Assertion macros shared by the max_xor_subarray block
`ifndef MAX_XOR_SUBARRAY_TOP_MACROS_SVH
`define MAX_XOR_SUBARRAY_TOP_MACROS_SVH

// Property checked on every clock edge outside reset
`define MXS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Overlapping implication checked on every clock edge outside reset
`define MXS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/mxs_pkg.sv]
// Package: constants and wave types for the max_xor_subarray block
`timescale 1ns / 1ps

package mxs_pkg;

	localparam int MAX_LEN   = 1024;
	localparam int VAL_W     = 31;
	localparam int POS_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W     = $clog2(MAX_LEN + 1);
	localparam int OUT_POS_W = 11;

	// control part of a wave, cleared at reset
	typedef struct packed {
		logic elem;   // wave carries an element that entered the chain
		logic last;   // wave closes the sequence
		logic drop;   // sequence lost elements beyond MAX_LEN
	} ctl_t;

	// payload part of a wave
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] pos;
		logic             cand_set;
		logic [VAL_W-1:0] cand_val;
		logic [POS_W-1:0] cand_start;
	} data_t;

endpackage

[hw/rtl/mxs_feed.sv]
// Input stage: numbers the elements, drops overflow and builds the wave
`timescale 1ns / 1ps

module mxs_feed (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [mxs_pkg::VAL_W-1:0]   value,
	input  logic                        last,
	output mxs_pkg::ctl_t               ctl,
	output mxs_pkg::data_t              data,
	output logic [mxs_pkg::CNT_W-1:0]   count
);

	logic [mxs_pkg::CNT_W-1:0] count_q;
	logic                      drop_q;
	logic                      full;

	assign full  = (count_q == mxs_pkg::CNT_W'(mxs_pkg::MAX_LEN));
	assign count = count_q;

	always_comb begin
		ctl.elem = take && !full;
		ctl.last = take && last;
		ctl.drop = drop_q || full;
		data.value      = value;
		data.pos        = count_q[mxs_pkg::POS_W-1:0];
		data.cand_set   = 1'b0;
		data.cand_val   = '0;
		data.cand_start = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (take) begin
			if (last) begin
				// sequence closes: start over for the next one
				count_q <= '0;
				drop_q  <= 1'b0;
			end else if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

[hw/rtl/mxs_cell.sv]
// Chain cell: holds the running XOR of the run opened at its own position
`timescale 1ns / 1ps

module mxs_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [mxs_pkg::POS_W-1:0]  idx,
	input  mxs_pkg::ctl_t              ctl_in,
	input  mxs_pkg::data_t             data_in,
	output mxs_pkg::ctl_t              ctl_out,
	output mxs_pkg::data_t             data_out
);

	logic [mxs_pkg::VAL_W-1:0] run_q;
	logic [mxs_pkg::VAL_W-1:0] x;
	logic                      active;
	logic                      better;
	mxs_pkg::ctl_t             ctl_s1;
	mxs_pkg::data_t            data_s1;
	mxs_pkg::data_t            data_nxt;

	assign active = ctl_in.elem && (data_in.pos >= idx);
	// open the run when the wave's position is this cell's own
	assign x      = (data_in.pos == idx) ? data_in.value : (run_q ^ data_in.value);
	// strict greater: a cell further down never beats an equal, earlier start
	assign better = active && (!data_in.cand_set || (x > data_in.cand_val));

	always_comb begin
		data_nxt = data_in;
		if (better) begin
			data_nxt.cand_set   = 1'b1;
			data_nxt.cand_val   = x;
			data_nxt.cand_start = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= data_nxt;
			if (active) begin
				run_q <= x;
			end
		end
	end

	assign ctl_out  = ctl_s1;
	assign data_out = data_s1;

endmodule

[hw/rtl/mxs_tally.sv]
// Chain tail: merges per-end winners and holds the result for the receiver
`timescale 1ns / 1ps

module mxs_tally (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  mxs_pkg::ctl_t                   ctl,
	input  mxs_pkg::data_t                  data,
	input  logic                            result_stall,
	output logic                            result_valid,
	output logic [mxs_pkg::VAL_W-1:0]       max_xor,
	output logic [mxs_pkg::OUT_POS_W-1:0]   first_pos,
	output logic [mxs_pkg::OUT_POS_W-1:0]   end_pos,
	output logic                            overflowed
);

	logic [mxs_pkg::VAL_W-1:0]     best_val_q;
	logic [mxs_pkg::POS_W-1:0]     best_start_q;
	logic [mxs_pkg::POS_W-1:0]     best_end_q;
	logic [mxs_pkg::VAL_W-1:0]     nxt_val;
	logic [mxs_pkg::POS_W-1:0]     nxt_start;
	logic [mxs_pkg::POS_W-1:0]     nxt_end;
	logic                          take;
	logic                          valid_q;
	logic [mxs_pkg::VAL_W-1:0]     max_xor_q;
	logic [mxs_pkg::OUT_POS_W-1:0] first_pos_q;
	logic [mxs_pkg::OUT_POS_W-1:0] end_pos_q;
	logic                          overflowed_q;
	logic [mxs_pkg::POS_W:0]       start_one;
	logic [mxs_pkg::POS_W:0]       end_one;

	// earlier ends arrive first, so an equal value only wins with a smaller start
	assign take = ctl.elem && ((data.pos == '0) || (data.cand_val > best_val_q) ||
		((data.cand_val == best_val_q) && (data.cand_start < best_start_q)));

	always_comb begin
		nxt_val   = take ? data.cand_val   : best_val_q;
		nxt_start = take ? data.cand_start : best_start_q;
		nxt_end   = take ? data.pos        : best_end_q;
		start_one = {1'b0, nxt_start} + 1'b1;
		end_one   = {1'b0, nxt_end} + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			best_val_q   <= nxt_val;
			best_start_q <= nxt_start;
			best_end_q   <= nxt_end;
			if (ctl.last) begin
				max_xor_q    <= nxt_val;
				first_pos_q  <= mxs_pkg::OUT_POS_W'(start_one);
				end_pos_q    <= mxs_pkg::OUT_POS_W'(end_one);
				overflowed_q <= ctl.drop;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance && ctl.last) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign max_xor      = max_xor_q;
	assign first_pos    = first_pos_q;
	assign end_pos      = end_pos_q;
	assign overflowed   = overflowed_q;

endmodule

[hw/rtl/max_xor_subarray_top.sv]
// Top level: maximum-XOR contiguous run over a streamed sequence
//
// Items come in on value/last under item_valid/item_stall; one request is
// taken at each edge where item_valid is high and item_stall is low. The
// item with last set closes the sequence, and one result (max_xor,
// first_pos, end_pos, overflowed) leaves under result_valid/result_stall.
// Positions count from 1; ties go to the smallest start, then smallest end.
// Elements past MAX_LEN are dropped and raise overflowed.
// Each element travels as a wave down a row of MAX_LEN cells, one cell per
// cycle while the row advances; cell s keeps the XOR of the run opened at
// position s. One item is taken per cycle while item_stall is low. The
// result is registered once the closing wave has passed the last cell.
// A stalled result freezes the whole row, so item_stall follows
// result_stall while a result waits. Reset empties the row and clears
// result_valid; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`include "max_xor_subarray_top_macros.svh"

module max_xor_subarray_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [mxs_pkg::VAL_W-1:0]       value,
	input  logic                            last,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [mxs_pkg::VAL_W-1:0]       max_xor,
	output logic [mxs_pkg::OUT_POS_W-1:0]   first_pos,
	output logic [mxs_pkg::OUT_POS_W-1:0]   end_pos,
	output logic                            overflowed
);

	logic                      advance;
	logic                      take;
	logic [mxs_pkg::CNT_W-1:0] count;
	logic                      count_open;
	logic                      tail_last;
	mxs_pkg::ctl_t             ctl_w  [0:mxs_pkg::MAX_LEN];
	mxs_pkg::data_t            data_w [0:mxs_pkg::MAX_LEN];

	// hold the row while a finished result is refused
	assign advance    = !(result_valid && result_stall);
	assign item_stall = !advance;
	assign take       = item_valid && advance;

	mxs_feed u_feed (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.value  (value),
		.last   (last),
		.ctl    (ctl_w[0]),
		.data   (data_w[0]),
		.count  (count)
	);

	for (genvar i = 0; i < mxs_pkg::MAX_LEN; i++) begin : g_cell
		mxs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.idx      (mxs_pkg::POS_W'(i)),
			.ctl_in   (ctl_w[i]),
			.data_in  (data_w[i]),
			.ctl_out  (ctl_w[i+1]),
			.data_out (data_w[i+1])
		);
	end

	mxs_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.ctl          (ctl_w[mxs_pkg::MAX_LEN]),
		.data         (data_w[mxs_pkg::MAX_LEN]),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.max_xor      (max_xor),
		.first_pos    (first_pos),
		.end_pos      (end_pos),
		.overflowed   (overflowed)
	);

	assign count_open = take && !last && (count < mxs_pkg::CNT_W'(mxs_pkg::MAX_LEN));
	assign tail_last  = advance && ctl_w[mxs_pkg::MAX_LEN].last;

	`MXS_ASSERT(a_count_bound, (count <= mxs_pkg::CNT_W'(mxs_pkg::MAX_LEN)), "count past MAX_LEN")
	`MXS_ASSERT(a_count_step, count_open |=> (count == $past(count) + 1'b1), "count did not advance")
	`MXS_ASSERT(a_tail_result, tail_last |=> result_valid, "closing wave gave no result")
	`MXS_ASSERT_IMP(a_stall_cause, item_stall, result_valid, "input stalled with no result waiting")

endmodule

[tb/tb_max_xor_subarray_top.sv]
// Testbench for max_xor_subarray_top: streamed sequences checked against a behavioural model
`timescale 1ns / 1ps
module tb_max_xor_subarray_top;

	localparam int VAL_W     = mxs_pkg::VAL_W;
	localparam int OUT_POS_W = mxs_pkg::OUT_POS_W;
	localparam int MAX_LEN   = mxs_pkg::MAX_LEN;

	typedef struct packed {
		logic [VAL_W-1:0]     max_xor;
		logic [OUT_POS_W-1:0] first_pos;
		logic [OUT_POS_W-1:0] end_pos;
		logic                 overflowed;
	} best_run_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             last;
		bit               typed;
		best_run_t        want;
	} vector_t;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	logic [VAL_W-1:0]     value;
	logic                 last;
	logic                 result_valid;
	logic                 result_stall;
	logic [VAL_W-1:0]     max_xor;
	logic [OUT_POS_W-1:0] first_pos;
	logic [OUT_POS_W-1:0] end_pos;
	logic                 overflowed;

	// behavioural model of the cell row
	logic [VAL_W-1:0] run_acc [MAX_LEN];
	int               seq_len;
	logic [VAL_W-1:0] best_xor;
	int               best_lo;
	int               best_hi;
	bit               dropped;

	best_run_t expected_best [$];
	vector_t   directed_rows [$];
	int        mismatches;
	int        results_seen;
	bit        sender_quiet;
	bit        hold_done;

	max_xor_subarray_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.max_xor      (max_xor),
		.first_pos    (first_pos),
		.end_pos      (end_pos),
		.overflowed   (overflowed)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Fold one element into every open run; return 1 with the best run when the sequence closes
	function automatic bit fold_element(input logic [VAL_W-1:0] v, input logic l,
			output best_run_t r);
		int p;
		r = '0;
		if (seq_len < MAX_LEN) begin
			p = seq_len;
			run_acc[p] = '0;
			for (int s = 0; s <= p; s++) begin
				run_acc[s] = run_acc[s] ^ v;
				// strict greater, or equal with an earlier start
				if (p == 0 || run_acc[s] > best_xor ||
						(run_acc[s] == best_xor && s < best_lo)) begin
					best_xor = run_acc[s];
					best_lo  = s;
					best_hi  = p;
				end
			end
			seq_len = p + 1;
		end else begin
			dropped = 1'b1;
		end
		if (!l)
			return 1'b0;
		r.max_xor    = best_xor;
		r.first_pos  = OUT_POS_W'(best_lo + 1);
		r.end_pos    = OUT_POS_W'(best_hi + 1);
		r.overflowed = dropped;
		seq_len  = 0;
		best_xor = '0;
		best_lo  = 0;
		best_hi  = 0;
		dropped  = 1'b0;
		return 1'b1;
	endfunction

	// Append one row to the directed table
	function automatic void add_row(input logic [VAL_W-1:0] v, input logic l, input bit typed,
			input logic [VAL_W-1:0] mx = '0, input int fp = 0, input int ep = 0,
			input logic ov = 1'b0);
		vector_t t;
		t.value = v;
		t.last  = l;
		t.typed = typed;
		t.want  = '{mx, OUT_POS_W'(fp), OUT_POS_W'(ep), ov};
		directed_rows = {directed_rows, t};
	endfunction

	// Offer one request, hold it until taken, then record what it should produce
	task automatic push_item(input logic [VAL_W-1:0] v, input logic l, input bit typed,
			input best_run_t want);
		best_run_t predicted;
		while (!sender_quiet && $urandom_range(99) < 12) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		value      <= v;
		last       <= l;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (fold_element(v, l, predicted)) begin
			if (typed)
				predicted = want;
			expected_best = {expected_best, predicted};
		end
	endtask

	initial begin
		int               sent;
		int               len;
		int               roll;
		bit               long_done;
		logic [VAL_W-1:0] v;
		item_valid   = 1'b0;
		value        = '0;
		last         = 1'b0;
		arst_n       = 1'b0;
		seq_len      = 0;
		best_xor     = '0;
		best_lo      = 0;
		best_hi      = 0;
		dropped      = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		sender_quiet = 1'b0;
		long_done    = 1'b0;
		sent         = 0;

		add_row(31'h0, 1'b1, 1, 31'h0, 1, 1);
		add_row(31'h7FFFFFFF, 1'b1, 1, 31'h7FFFFFFF, 1, 1);
		add_row(31'h5, 1'b0, 0);
		add_row(31'h5, 1'b1, 1, 31'h5, 1, 1);
		add_row(31'h0, 1'b0, 0);
		add_row(31'h0, 1'b0, 0);
		add_row(31'h0, 1'b1, 1, 31'h0, 1, 1);
		add_row(31'h1, 1'b0, 0);
		add_row(31'h2, 1'b0, 0);
		add_row(31'h4, 1'b1, 1, 31'h7, 1, 3);
		add_row(31'h7FFFFFFF, 1'b0, 0);
		add_row(31'h7FFFFFFF, 1'b0, 0);
		add_row(31'h7FFFFFFF, 1'b1, 1, 31'h7FFFFFFF, 1, 1);
		add_row(31'h40000000, 1'b0, 0);
		add_row(31'h3FFFFFFF, 1'b1, 1, 31'h7FFFFFFF, 1, 2);
		add_row(31'h2AAAAAAA, 1'b0, 0);
		add_row(31'h55555555, 1'b1, 1, 31'h7FFFFFFF, 1, 2);
		add_row(31'h3, 1'b0, 0);
		add_row(31'h1, 1'b0, 0);
		add_row(31'h2, 1'b1, 0);
		add_row(31'h6, 1'b0, 0);
		add_row(31'h6, 1'b0, 0);
		add_row(31'h6, 1'b1, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			push_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].want);

		while (sent < 1600) begin
			roll = $urandom_range(99);
			if (!long_done && sent >= 300) begin
				// overrun the row; the closing request is itself dropped
				len       = MAX_LEN + 3;
				long_done = 1'b1;
			end else if (roll < 70) begin
				len = $urandom_range(1, 8);
			end else if (roll < 95) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(41, 200);
			end
			for (int k = 0; k < len; k++) begin
				roll = $urandom_range(99);
				if (roll < 60)
					v = VAL_W'($urandom);
				else if (roll < 85)
					v = VAL_W'($urandom_range(0, 15));
				else if (roll < 92)
					v = {VAL_W{1'b1}};
				else
					v = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
				sender_quiet = (sent >= 500 && sent < 800);
				push_item(v, (k == len - 1), 0, '0);
				sent++;
			end
		end
		item_valid <= 1'b0;

		while (expected_best.size() != 0)
			@(posedge clk);
		repeat (MAX_LEN + 50) @(posedge clk);
		if (mismatches == 0 && expected_best.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random stalls, a quiet stretch, and one long hold-off to back the row up
	initial begin
		int hold_left;
		result_stall = 1'b0;
		hold_done    = 1'b0;
		hold_left    = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 4) begin
				hold_done    = 1'b1;
				hold_left    = 3000;
				result_stall <= 1'b1;
			end else if (results_seen >= 20 && results_seen < 40) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < 12);
			end
		end
	end

	always @(posedge clk) begin
		best_run_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_best.size() == 0) begin
				mismatches++;
				$error("result with none pending: max_xor %0h first_pos %0d end_pos %0d",
					max_xor, first_pos, end_pos);
			end else begin
				want = expected_best.pop_front();
				if (max_xor !== want.max_xor) begin
					mismatches++;
					$error("max_xor: expected %0h, got %0h", want.max_xor, max_xor);
				end
				if (first_pos !== want.first_pos) begin
					mismatches++;
					$error("first_pos: expected %0d, got %0d", want.first_pos, first_pos);
				end
				if (end_pos !== want.end_pos) begin
					mismatches++;
					$error("end_pos: expected %0d, got %0d", want.end_pos, end_pos);
				end
				if (overflowed !== want.overflowed) begin
					mismatches++;
					$error("overflowed: expected %0b, got %0b", want.overflowed, overflowed);
				end
			end
		end
	end

	initial begin
		#(200000 * 20);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
